@@ hdl/assert_macros.svh @@
// Assertion macros for the mapper RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/mmb_pkg.sv @@
// Types, codes and the 7-bit scaling function for the MIDI binding mapper.
// No dependencies.
package mmb_pkg;

  // binding / learn source codes; 6 and 7 have no meaning and act as none
  typedef enum logic [2:0] {
    SRC_NONE  = 3'd0,
    SRC_CC    = 3'd1,
    SRC_GATE  = 3'd2,
    SRC_VEL   = 3'd3,
    SRC_NUM   = 3'd4,
    SRC_PITCH = 3'd5
  } src_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BIND_SOURCE  = 2'd0,
    CFG_BIND_CHANNEL = 2'd1,
    CFG_BIND_NUMBER  = 2'd2,
    CFG_ARMED_SOURCE = 2'd3
  } cfg_idx_t;

  // status high nibble
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CC       = 4'hB;
  localparam logic [3:0] KIND_PITCH    = 4'hE;

  localparam int CFG_DATA_W   = 7;
  localparam int MAP_VALUE_W  = 17;
  localparam int MAX_FRAC     = 24;
  localparam int MAX_VAL_W    = MAX_FRAC + 1;

  localparam logic [4:0] CHAN_MIN = 5'd1;
  localparam logic [4:0] CHAN_MAX = 5'd16;
  localparam logic signed [7:0] LEARN_NUM_NONE = -8'sd1;

  // how the value is formed
  typedef enum logic [1:0] {
    SCL_ZERO,   // note-off or no hit
    SCL_ONE,    // gate on: full scale
    SCL_LUT,    // 7-bit value over 127
    SCL_WHEEL   // 14-bit wheel over 16383
  } scale_mode_t;

  typedef struct packed {
    scale_mode_t  mode;
    logic [6:0]   lut_in;
    logic [13:0]  wheel;
  } scale_req_t;

  // round(x * 2^frac_bits / 127), evaluated at elaboration only
  function automatic logic [MAX_VAL_W-1:0] scale_by_127(input int unsigned frac_bits,
                                                        input int unsigned x);
    logic [63:0] n;
    n = (64'(x) << frac_bits) + 64'd63;
    return MAX_VAL_W'(n / 64'd127);
  endfunction

endpackage

@@ hdl/mmb_scale.sv @@
// Value scaling for the mapper: 7-bit table over 127, 14-bit wheel over 16383.
// Depends on mmb_pkg. Purely combinational.
module mmb_scale import mmb_pkg::*; #(
  parameter int VALUE_FRACTION_BITS = 16
) (
  input  scale_req_t              req,
  output logic [MAP_VALUE_W-1:0]  value
);

  localparam int F  = VALUE_FRACTION_BITS;
  localparam int VW = F + 1;                       // holds 2^F
  localparam int TW = F + 15;                      // wheel * 2^F + 8191
  localparam int SW = ((VW > 14) ? VW : 14) + 1;   // hi + lo
  localparam int H2W = SW - 14;

  // constant table, one entry per 7-bit value
  logic [VW-1:0] lut [128];
  for (genvar i = 0; i < 128; i++) begin : g_lut
    assign lut[i] = VW'(scale_by_127(F, i));
  end

  // wheel: t / 16383 with 16383 = 2^14 - 1, folded twice
  logic [TW-1:0]  t;
  logic [VW-1:0]  hi;
  logic [SW-1:0]  s;
  logic [H2W-1:0] h2;
  logic [14:0]    u;
  logic           corr;
  logic [VW-1:0]  wheel_q;

  assign t       = (TW'(req.wheel) << F) + TW'(8191);
  assign hi      = t[TW-1:14];
  assign s       = SW'(hi) + SW'(t[13:0]);
  assign h2      = s[SW-1:14];
  assign u       = 15'(s[13:0]) + 15'(h2);
  assign corr    = (u >= 15'd16383);
  assign wheel_q = hi + VW'(h2) + VW'(corr);

  logic [VW-1:0] full;
  always_comb begin
    case (req.mode)
      SCL_ONE:   full = VW'(1) << F;
      SCL_LUT:   full = lut[req.lut_in];
      SCL_WHEEL: full = wheel_q;
      default:   full = '0;
    endcase
  end

  assign value = MAP_VALUE_W'(full);

endmodule

@@ hdl/midi_message_binding_mapper_unit.sv @@
// A word taken while start is high and busy low passes the input register and
// the result register to the out_ ports, flagged by out_strobe for one cycle.
// Throughput: one word per cycle; busy is never raised, the input register
// and the result register let a new word enter every cycle.
// Reset (rst_n low, synchronous): config returns to source none, channel 1,
// number 0, nothing armed; words in flight are dropped.
// Depends on mmb_pkg, mmb_scale and assert_macros.svh.
`include "assert_macros.svh"
module midi_message_binding_mapper_unit import mmb_pkg::*; #(
  parameter int VALUE_FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // command channel
  input  logic                   start,
  output logic                   busy,
  input  logic [7:0]             in_status_byte,
  input  logic [6:0]             in_first_data,
  input  logic [6:0]             in_second_data,
  // results
  output logic                   out_strobe,
  output logic                   out_map_hit,
  output logic [MAP_VALUE_W-1:0] out_map_value,
  output logic                   out_learn_hit,
  output logic [4:0]             out_learned_channel,
  output logic signed [7:0]      out_learned_number,
  // config writes
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  src_t       bind_source_r;
  logic [4:0] bind_channel_r;
  logic [6:0] bind_number_r;
  src_t       armed_source_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bind_source_r  <= SRC_NONE;
      bind_channel_r <= CHAN_MIN;
      bind_number_r  <= '0;
      armed_source_r <= SRC_NONE;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BIND_SOURCE:  bind_source_r  <= src_t'(cfg_data[2:0]);
        CFG_BIND_CHANNEL: bind_channel_r <= cfg_data[4:0];
        CFG_BIND_NUMBER:  bind_number_r  <= cfg_data[6:0];
        CFG_ARMED_SOURCE: armed_source_r <= src_t'(cfg_data[2:0]);
        default: ;
      endcase
    end
  end

  // never stalls
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       s1_valid_r;
  logic [7:0] s1_status_r;
  logic [6:0] s1_d1_r;
  logic [6:0] s1_d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_status_r <= in_status_byte;
      s1_d1_r     <= in_first_data;
      s1_d2_r     <= in_second_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Message decode
  // ---------------------------------------------------------------------------
  logic [3:0] kind;
  logic [4:0] chan;
  logic       is_cc, is_on, is_off, is_pw;

  assign kind   = s1_status_r[7:4];
  assign chan   = 5'(s1_status_r[3:0]) + 5'd1;
  assign is_cc  = (kind == KIND_CC);
  assign is_on  = (kind == KIND_NOTE_ON) && (s1_d2_r != '0);
  // note-on with zero velocity is a release
  assign is_off = (kind == KIND_NOTE_OFF) || ((kind == KIND_NOTE_ON) && (s1_d2_r == '0));
  assign is_pw  = (kind == KIND_PITCH);

  // bound channel clamped into 1..16
  logic [4:0] bind_chan;
  always_comb begin
    if (bind_channel_r < CHAN_MIN) begin
      bind_chan = CHAN_MIN;
    end else if (bind_channel_r > CHAN_MAX) begin
      bind_chan = CHAN_MAX;
    end else begin
      bind_chan = bind_channel_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Binding match: hit flag plus a scaling request
  // ---------------------------------------------------------------------------
  logic       map_hit_nxt;
  scale_req_t req;
  logic       chan_ok, num_ok;

  assign chan_ok = (chan == bind_chan);
  assign num_ok  = (s1_d1_r == bind_number_r);

  always_comb begin
    map_hit_nxt = 1'b0;
    req.mode    = SCL_ZERO;
    req.lut_in  = s1_d2_r;
    req.wheel   = {s1_d2_r, s1_d1_r};
    unique case (bind_source_r) inside
      SRC_CC: begin
        if (chan_ok && is_cc && num_ok) begin
          map_hit_nxt = 1'b1;
          req.mode    = SCL_LUT;
        end
      end
      SRC_GATE, SRC_VEL, SRC_NUM: begin
        if (chan_ok && (is_on || is_off) && num_ok) begin
          map_hit_nxt = 1'b1;
          // off leaves the value at zero
          if (is_on) begin
            if (bind_source_r == SRC_GATE) begin
              req.mode = SCL_ONE;
            end else begin
              req.mode = SCL_LUT;
            end
          end
        end
        if (bind_source_r == SRC_NUM) begin
          req.lut_in = s1_d1_r;
        end
      end
      SRC_PITCH: begin
        // number is ignored for the wheel
        if (chan_ok && is_pw) begin
          map_hit_nxt = 1'b1;
          req.mode    = SCL_WHEEL;
        end
      end
      default: ;
    endcase
  end

  logic [MAP_VALUE_W-1:0] map_value_nxt;

  mmb_scale #(
    .VALUE_FRACTION_BITS (VALUE_FRACTION_BITS)
  ) u_scale (
    .req   (req),
    .value (map_value_nxt)
  );

  // ---------------------------------------------------------------------------
  // Learn capture for the armed source
  // ---------------------------------------------------------------------------
  logic              learn_hit_nxt;
  logic [4:0]        learned_channel_nxt;
  logic signed [7:0] learned_number_nxt;

  always_comb begin
    learn_hit_nxt      = 1'b0;
    learned_number_nxt = LEARN_NUM_NONE;
    unique case (armed_source_r) inside
      SRC_CC: begin
        if (is_cc) begin
          learn_hit_nxt      = 1'b1;
          learned_number_nxt = 8'(s1_d1_r);
        end
      end
      SRC_GATE, SRC_VEL, SRC_NUM: begin
        // a zero-velocity note-on does not count here
        if (is_on) begin
          learn_hit_nxt      = 1'b1;
          learned_number_nxt = 8'(s1_d1_r);
        end
      end
      SRC_PITCH: begin
        learn_hit_nxt = is_pw;
      end
      default: ;
    endcase
    learned_channel_nxt = learn_hit_nxt ? chan : 5'd0;
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic                   out_strobe_r;
  logic                   map_hit_r;
  logic [MAP_VALUE_W-1:0] map_value_r;
  logic                   learn_hit_r;
  logic [4:0]             learned_channel_r;
  logic signed [7:0]      learned_number_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      map_hit_r         <= map_hit_nxt;
      map_value_r       <= map_value_nxt;
      learn_hit_r       <= learn_hit_nxt;
      learned_channel_r <= learned_channel_nxt;
      learned_number_r  <= learned_number_nxt;
    end
  end

  assign out_strobe          = out_strobe_r;
  assign out_map_hit         = map_hit_r;
  assign out_map_value       = map_value_r;
  assign out_learn_hit       = learn_hit_r;
  assign out_learned_channel = learned_channel_r;
  assign out_learned_number  = learned_number_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ASSERT_NEXT(a_accept_to_s1, clk, rst_n, start && !busy, s1_valid_r)
  `ASSERT_NEXT(a_s1_to_out, clk, rst_n, s1_valid_r, out_strobe)
  `ASSERT_IMPLIES(a_miss_zero, clk, rst_n, out_strobe && !out_map_hit, out_map_value == '0)
  `ASSERT_IMPLIES(a_nolearn_clear, clk, rst_n, out_strobe && !out_learn_hit, (out_learned_channel == 5'd0) && (out_learned_number == LEARN_NUM_NONE))
  `ASSERT_IMPLIES(a_learn_chan, clk, rst_n, out_strobe && out_learn_hit, (out_learned_channel >= CHAN_MIN) && (out_learned_channel <= CHAN_MAX))

endmodule

@@ tb/sv/mmb_result_checker.sv @@
// Result checker for midi_message_binding_mapper_unit: tracks config writes,
// predicts each accepted word's result and compares it with what comes out.
// Depends on mmb_pkg.
module mmb_result_checker import mmb_pkg::*; #(
  parameter int VALUE_FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  logic [7:0]             in_status_byte,
  input  logic [6:0]             in_first_data,
  input  logic [6:0]             in_second_data,
  input  logic                   out_strobe,
  input  logic                   out_map_hit,
  input  logic [MAP_VALUE_W-1:0] out_map_value,
  input  logic                   out_learn_hit,
  input  logic [4:0]             out_learned_channel,
  input  logic signed [7:0]      out_learned_number,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned DATA7_FULL_SCALE = 127;
  localparam longint unsigned WHEEL_FULL_SCALE = 16383;

  typedef struct packed {
    logic                   map_hit;
    logic [MAP_VALUE_W-1:0] map_value;
    logic                   learn_hit;
    logic [4:0]             learned_channel;
    logic signed [7:0]      learned_number;
  } map_result_t;

  // shadow of the binding registers
  logic [2:0] bind_src_q;
  logic [4:0] bind_chan_q;
  logic [6:0] bind_num_q;
  logic [2:0] armed_src_q;

  map_result_t expected_results[$];

  initial begin
    fail_count    = 0;
    pending_words = 0;
  end

  // round(num * 2^F / den)
  function automatic logic [MAP_VALUE_W-1:0] ratio_round(input longint unsigned num,
                                                         input longint unsigned den);
    longint unsigned q;
    q = ((num << VALUE_FRACTION_BITS) + den / 2) / den;
    return MAP_VALUE_W'(q);
  endfunction

  function automatic map_result_t predict_mapping(input logic [7:0] status,
                                                  input logic [6:0] num7,
                                                  input logic [6:0] data7);
    logic [3:0]  kind;
    logic [4:0]  chan;
    logic [4:0]  bound_chan;
    logic        cc_msg, on_msg, off_msg, wheel_msg;
    map_result_t r;
    kind      = status[7:4];
    chan      = {1'b0, status[3:0]} + 5'd1;
    cc_msg    = (kind == KIND_CC);
    on_msg    = (kind == KIND_NOTE_ON) && (data7 != 7'd0);
    // note-on with zero velocity is a note-off
    off_msg   = (kind == KIND_NOTE_OFF) || ((kind == KIND_NOTE_ON) && (data7 == 7'd0));
    wheel_msg = (kind == KIND_PITCH);
    bound_chan = (bind_chan_q < CHAN_MIN) ? CHAN_MIN :
                 (bind_chan_q > CHAN_MAX) ? CHAN_MAX : bind_chan_q;
    r = '0;
    r.learned_number = LEARN_NUM_NONE;

    if (chan == bound_chan) begin
      case (bind_src_q)
        SRC_CC: begin
          if (cc_msg && num7 == bind_num_q) begin
            r.map_hit   = 1'b1;
            r.map_value = ratio_round(data7, DATA7_FULL_SCALE);
          end
        end
        SRC_GATE, SRC_VEL, SRC_NUM: begin
          if ((on_msg || off_msg) && num7 == bind_num_q) begin
            r.map_hit = 1'b1;
            if (on_msg) begin
              if (bind_src_q == SRC_GATE)
                r.map_value = MAP_VALUE_W'(64'd1 << VALUE_FRACTION_BITS);
              else if (bind_src_q == SRC_VEL)
                r.map_value = ratio_round(data7, DATA7_FULL_SCALE);
              else
                r.map_value = ratio_round(num7, DATA7_FULL_SCALE);
            end
          end
        end
        SRC_PITCH: begin
          if (wheel_msg) begin
            r.map_hit   = 1'b1;
            r.map_value = ratio_round({data7, num7}, WHEEL_FULL_SCALE);
          end
        end
        default: ;
      endcase
    end

    case (armed_src_q)
      SRC_CC: begin
        if (cc_msg) begin
          r.learn_hit      = 1'b1;
          r.learned_number = {1'b0, num7};
        end
      end
      SRC_GATE, SRC_VEL, SRC_NUM: begin
        if (on_msg) begin
          r.learn_hit      = 1'b1;
          r.learned_number = {1'b0, num7};
        end
      end
      SRC_PITCH: begin
        if (wheel_msg) r.learn_hit = 1'b1;
      end
      default: ;
    endcase
    if (r.learn_hit) r.learned_channel = chan;
    return r;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    map_result_t want;
    if (!rst_n) begin
      bind_src_q  <= SRC_NONE;
      bind_chan_q <= CHAN_MIN;
      bind_num_q  <= '0;
      armed_src_q <= SRC_NONE;
      expected_results.delete();
    end else begin
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word, expected none, actual hit %0b value %0d",
                   $time, out_map_hit, out_map_value);
        end else begin
          want = expected_results.pop_front();
          check_field("map_hit", want.map_hit, out_map_hit);
          check_field("map_value", want.map_value, out_map_value);
          check_field("learn_hit", want.learn_hit, out_learn_hit);
          check_field("learned_channel", want.learned_channel, out_learned_channel);
          check_field("learned_number", $signed(want.learned_number),
                      $signed(out_learned_number));
        end
      end
      if (start && !busy)
        expected_results.push_back(predict_mapping(in_status_byte, in_first_data,
                                                   in_second_data));
      if (cfg_we) begin
        case (cfg_index)
          CFG_BIND_SOURCE:  bind_src_q  <= cfg_data[2:0];
          CFG_BIND_CHANNEL: bind_chan_q <= cfg_data[4:0];
          CFG_BIND_NUMBER:  bind_num_q  <= cfg_data[6:0];
          CFG_ARMED_SOURCE: armed_src_q <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
    pending_words = expected_results.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Top of the MIDI binding mapper testbench: clock, reset, config phases and
// message stimulus; the verdict comes from the failure count of the checker.
// Depends on mmb_pkg, midi_message_binding_mapper_unit and mmb_result_checker.
module tb_top import mmb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 16;
  // source codes without a meaning; the block treats them as none
  localparam logic [2:0] SRC_SPARE_LO = 3'd6;
  localparam logic [2:0] SRC_SPARE_HI = 3'd7;
  localparam int RANDOM_PHASES   = 10;
  localparam int WORDS_PER_PHASE = 95;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [7:0]             in_status_byte;
  logic [6:0]             in_first_data;
  logic [6:0]             in_second_data;
  logic                   out_strobe;
  logic                   out_map_hit;
  logic [MAP_VALUE_W-1:0] out_map_value;
  logic                   out_learn_hit;
  logic [4:0]             out_learned_channel;
  logic signed [7:0]      out_learned_number;
  logic                   cfg_we;
  logic [1:0]             cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int                     fail_count;
  int                     pending_words;

  // what was last written, used to aim messages at the binding
  logic [2:0] cur_src;
  logic [4:0] cur_chan;
  logic [6:0] cur_num;

  midi_message_binding_mapper_unit #(
    .VALUE_FRACTION_BITS(FRAC_BITS)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_status_byte      (in_status_byte),
    .in_first_data       (in_first_data),
    .in_second_data      (in_second_data),
    .out_strobe          (out_strobe),
    .out_map_hit         (out_map_hit),
    .out_map_value       (out_map_value),
    .out_learn_hit       (out_learn_hit),
    .out_learned_channel (out_learned_channel),
    .out_learned_number  (out_learned_number),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  mmb_result_checker #(
    .VALUE_FRACTION_BITS(FRAC_BITS)
  ) i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_status_byte      (in_status_byte),
    .in_first_data       (in_first_data),
    .in_second_data      (in_second_data),
    .out_strobe          (out_strobe),
    .out_map_hit         (out_map_hit),
    .out_map_value       (out_map_value),
    .out_learn_hit       (out_learn_hit),
    .out_learned_channel (out_learned_channel),
    .out_learned_number  (out_learned_number),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .pending_words       (pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Drive one word at the falling edge and hold it until start && !busy
  // is seen at a rising edge. The next call (or an idle cycle) reassigns
  // start at a later falling edge, so start is never dropped and re-raised
  // in one time step.
  task automatic send_word(input logic [7:0] status, input logic [6:0] num7,
                           input logic [6:0] data7);
    @(negedge clk);
    start          <= 1'b1;
    in_status_byte <= status;
    in_first_data  <= num7;
    in_second_data <= data7;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // idle cycles carry junk on the data ports to show start gates them
  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start          <= 1'b0;
      in_status_byte <= 8'($urandom_range(255));
      in_first_data  <= 7'($urandom_range(127));
      in_second_data <= 7'($urandom_range(127));
    end
  endtask

  // Every word yields one result, so an empty expectation queue means the
  // pipe is empty; the trailing idle cycles cover the two register stages anyway.
  // pending_words is read at the falling edge, after the checker updated it.
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
  endtask

  // new binding and learn setup, only ever written with the block idle
  task automatic load_binding(input logic [2:0] src, input logic [4:0] chan,
                              input logic [6:0] num, input logic [2:0] armed);
    wait_idle();
    write_reg(CFG_BIND_SOURCE, CFG_DATA_W'(src));
    write_reg(CFG_BIND_CHANNEL, CFG_DATA_W'(chan));
    write_reg(CFG_BIND_NUMBER, num);
    write_reg(CFG_ARMED_SOURCE, CFG_DATA_W'(armed));
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_src  = src;
    cur_chan = chan;
    cur_num  = num;
  endtask

  // data byte biased toward its limits
  function automatic logic [6:0] data_with_limits();
    case ($urandom_range(7))
      0:       return 7'd0;
      1:       return 7'd127;
      default: return 7'($urandom_range(127));
    endcase
  endfunction

  function automatic logic [3:0] any_kind();
    case ($urandom_range(3))
      0:       return KIND_NOTE_OFF;
      1:       return KIND_NOTE_ON;
      2:       return KIND_CC;
      default: return KIND_PITCH;
    endcase
  endfunction

  // status low nibble of the bound channel after the block's clamp
  function automatic logic [3:0] bound_nibble();
    if (cur_chan < CHAN_MIN) return 4'd0;
    if (cur_chan > CHAN_MAX) return 4'd15;
    return 4'(cur_chan - 5'd1);
  endfunction

  // Mostly messages aimed at the binding (right kind, channel and number,
  // random payload), the rest random channel messages and raw status bytes.
  task automatic random_word();
    logic [3:0]  kind;
    logic [3:0]  chan_nib;
    logic [6:0]  num7;
    logic [6:0]  data7;
    int unsigned pick;
    pick     = $urandom_range(9);
    chan_nib = ($urandom_range(6) == 0) ? 4'($urandom_range(15)) : bound_nibble();
    num7     = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : cur_num;
    data7    = data_with_limits();
    if (pick < 6) begin
      case (cur_src)
        SRC_CC:    kind = KIND_CC;
        SRC_PITCH: kind = KIND_PITCH;
        SRC_GATE, SRC_VEL, SRC_NUM: begin
          case ($urandom_range(3))
            0: kind = KIND_NOTE_OFF;
            1: begin
              kind  = KIND_NOTE_ON;
              data7 = 7'd0;   // zero velocity: acts as note-off
            end
            default: kind = KIND_NOTE_ON;
          endcase
        end
        default:   kind = any_kind();
      endcase
      if (kind == KIND_PITCH) num7 = data_with_limits();
      send_word({kind, chan_nib}, num7, data7);
    end else if (pick < 9) begin
      send_word({any_kind(), 4'($urandom_range(15))}, 7'($urandom_range(127)), data7);
    end else begin
      send_word(8'($urandom_range(255)), 7'($urandom_range(127)), data7);
    end
  endtask

  initial begin
    logic steady;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_status_byte = '0;
    in_first_data  = '0;
    in_second_data = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_BIND_SOURCE;
    cfg_data       = '0;
    cur_src        = SRC_NONE;
    cur_chan       = CHAN_MIN;
    cur_num        = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    // controller 127 on channel register 0, which clamps up to channel 1
    load_binding(SRC_CC, 5'd0, 7'd127, SRC_CC);
    send_word({KIND_CC, 4'd0}, 7'd127, 7'd0);
    send_word({KIND_CC, 4'd0}, 7'd127, 7'd127);
    send_word({KIND_CC, 4'd0}, 7'd0, 7'd64);      // learn only
    send_word({KIND_CC, 4'd15}, 7'd127, 7'd127);  // wrong channel
    send_word(8'h00, 7'd0, 7'd0);                 // data byte as status
    send_word(8'h7F, 7'd127, 7'd127);
    send_word(8'hF0, 7'd127, 7'd127);             // system messages
    send_word(8'hFF, 7'd127, 7'd127);
    // gate on note 0, channel register 31 clamps down to 16
    load_binding(SRC_GATE, 5'd31, 7'd0, SRC_VEL);
    send_word({KIND_NOTE_ON, 4'd15}, 7'd0, 7'd127);
    send_word({KIND_NOTE_ON, 4'd15}, 7'd0, 7'd0);   // zero velocity note-on
    send_word({KIND_NOTE_OFF, 4'd15}, 7'd0, 7'd127);
    send_word({KIND_NOTE_ON, 4'd15}, 7'd1, 7'd127); // other note
    load_binding(SRC_VEL, 5'd16, 7'd127, SRC_NUM);
    send_word({KIND_NOTE_ON, 4'd15}, 7'd127, 7'd1);
    send_word({KIND_NOTE_ON, 4'd15}, 7'd127, 7'd127);
    load_binding(SRC_NUM, 5'd5, 7'd64, SRC_GATE);
    send_word({KIND_NOTE_ON, 4'd4}, 7'd64, 7'd64);
    send_word({KIND_NOTE_OFF, 4'd4}, 7'd64, 7'd0);
    // wheel ignores the number register
    load_binding(SRC_PITCH, 5'd1, 7'd99, SRC_PITCH);
    send_word({KIND_PITCH, 4'd0}, 7'd0, 7'd0);
    send_word({KIND_PITCH, 4'd0}, 7'd127, 7'd127);
    send_word({KIND_PITCH, 4'd0}, 7'd0, 7'd64);
    // spare codes: never a hit
    load_binding(SRC_SPARE_HI, 5'd1, 7'd0, SRC_SPARE_LO);
    send_word({KIND_CC, 4'd0}, 7'd0, 7'd0);
    send_word({KIND_PITCH, 4'd0}, 7'd0, 7'd0);

    // --- random part ---
    // phases sweep every source code and the channel / number extremes;
    // two phases run back to back with no idle cycles
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_binding(p < 8 ? 3'(p) : 3'($urandom_range(SRC_CC, SRC_PITCH)),
                   p == 1 ? 5'd0 : p == 2 ? 5'd31 : p == 3 ? 5'd16
                                 : 5'($urandom_range(31)),
                   p == 4 ? 7'd127 : p == 5 ? 7'd0 : 7'($urandom_range(127)),
                   3'((p + 3) % 8));
      steady = (p == 6 || p == 7);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (!steady && $urandom_range(99) < 35) idle_cycles($urandom_range(1, 3));
        random_word();
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
